@@ rtl/kpd_ar_pkg.sv @@
// Shared types, constants and key table for the keypad override and autorepeat core.
// No dependencies; imported by the core and by its checker.

package kpd_ar_pkg;

    // Key table size, group override masks and special bits of word two
    localparam int          TABLE_KEYS = 14;
    localparam logic [31:0] GRP_MASK0  = 32'h0000_000C;
    localparam logic [31:0] GRP_MASK1  = 32'h1F1F_0300;
    localparam logic [31:0] RO_FLAG    = 32'h0002_0000;
    localparam logic [31:0] REMOTE_BIT = 32'h0004_0000;
    localparam logic [15:0] LEN_MAX    = 16'hFFFF;

    // Register reset values
    localparam logic [3:0]  ALT_KEY_RESET      = 4'd1;
    localparam logic [15:0] FIRST_DELAY_RESET  = 16'd500;
    localparam logic [15:0] REPEAT_DELAY_RESET = 16'd175;

    // Configuration register indexes
    localparam logic [1:0] CFG_ALT_KEY      = 2'd0;
    localparam logic [1:0] CFG_REMOTE_EN    = 2'd1;
    localparam logic [1:0] CFG_FIRST_DELAY  = 2'd2;
    localparam logic [1:0] CFG_REPEAT_DELAY = 2'd3;

    // Input word operations
    typedef enum logic [2:0] {
        MODE_SCAN          = 3'd0,
        MODE_VPRESS        = 3'd1,
        MODE_VRELEASE      = 3'd2,
        MODE_RELEASE_ALL   = 3'd3,
        MODE_CLEAR_REPEAT  = 3'd4
    } mode_t;

    // One result word
    typedef struct packed {
        logic [31:0] word0;
        logic [31:0] word1;
        logic [31:0] word2;
        logic [3:0]  pressed;
        logic [3:0]  clicked;
        logic [3:0]  rpt_key;
        logic        level;
        logic [15:0] pulse_len;
        logic        pulse_done;
    } res_t;

    // Switch bits of key k (1-based); zero for keys outside the table
    function automatic logic [31:0] key_mask(input logic [3:0] k);
        logic [31:0] m;
        case (k)
            4'd1:    m = 32'h1000_0000;
            4'd2:    m = 32'h0000_0100;
            4'd3:    m = 32'h0000_0200;
            4'd4:    m = 32'h0010_0000;
            4'd5:    m = 32'h0002_0000;
            4'd6:    m = 32'h0008_0000;
            4'd7:    m = 32'h0200_0000;
            4'd8:    m = 32'h0400_0000;
            4'd9:    m = 32'h0001_0000;
            4'd10:   m = 32'h0100_0000;
            4'd11:   m = 32'h0004_0000;
            4'd12:   m = 32'h0800_0000;
            4'd13:   m = 32'h0000_000C;
            4'd14:   m = 32'h0000_0004;
            default: m = 32'h0000_0000;
        endcase
        return m;
    endfunction

    // Word group of key k: 1 for word one, 0 for word zero
    function automatic logic key_grp(input logic [3:0] k);
        return (k >= 4'd1) && (k <= 4'd12);
    endfunction

    // Active low: a key is held when every one of its bits reads zero
    function automatic logic key_held(input logic [31:0] w0, input logic [31:0] w1,
                                      input logic [3:0] k);
        logic [31:0] w;
        w = key_grp(k) ? w1 : w0;
        return (w & key_mask(k)) == 32'h0;
    endfunction

endpackage

@@ rtl/keypad_override_autorepeat_core.sv @@
// Keypad override and autorepeat core: top level.
// Depends on kpd_ar_pkg (key table, result type, codes).

// Front end for a 14-key active-low switch matrix. Each input word is either
// a scan tick (mode 0) carrying the three raw switch words, or a command that
// edits the virtual-press mask (press, release, release all) or drops the
// autorepeat key. Every input word gives exactly one result word; commands give
// an all-zero result. The block takes one input word per clock while in_stall is
// low, and the result is registered: all the work is a single combinational pass
// from the accepted input and the held state into an output
// register. A second (skid) result register lets the input keep flowing for one
// more word while the output is stalled, so in_stall rises only when both result
// registers are full. Sustained rate is one word per cycle whenever the consumer
// takes words. Configuration writes land at once and are meant for idle times.
// Only the previous scan (scan0_reg, scan1_reg) is kept for click detection; the
// virtual mask of word two never changes, so only words zero and one hold a mask.

module keypad_override_autorepeat_core #(
    parameter int KEY_COUNT        = 14,
    parameter int PULSE_COUNT_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // Input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  mode,
    input  logic [3:0]  key_index,
    input  logic [31:0] raw_word0,
    input  logic [31:0] raw_word1,
    input  logic [31:0] raw_word2,
    input  logic        override_on,
    input  logic [31:0] now_ms,
    // Output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] out_word0,
    output logic [31:0] out_word1,
    output logic [31:0] out_word2,
    output logic [3:0]  pressed_key,
    output logic [3:0]  clicked_key,
    output logic [3:0]  repeat_key,
    output logic        remote_level,
    output logic [15:0] remote_pulse_len,
    output logic        remote_pulse_done
);

    import kpd_ar_pkg::*;

    // Keys beyond the table do not exist
    localparam int          KEY_LIM   = (KEY_COUNT < TABLE_KEYS) ? KEY_COUNT : TABLE_KEYS;
    localparam logic [3:0]  KEY_LIM_V = 4'(KEY_LIM);
    localparam logic [PULSE_COUNT_BITS-1:0] TICK_SAT = '1;

    // Configuration registers
    logic [3:0]  alt_key_reg;
    logic        remote_en_reg;
    logic [15:0] first_delay_reg;
    logic [15:0] repeat_delay_reg;

    // Block state
    logic [31:0] scan0_reg, scan0_next;
    logic [31:0] scan1_reg, scan1_next;
    logic [31:0] vmask0_reg, vmask0_next;
    logic [31:0] vmask1_reg, vmask1_next;
    logic [3:0]  rpt_key_reg, rpt_key_next;
    logic [31:0] rpt_time_reg, rpt_time_next;
    logic        rpt_started_reg, rpt_started_next;
    logic [PULSE_COUNT_BITS-1:0] ticks_reg, ticks_next;

    // Result buffering
    logic  out_valid_reg, out_valid_next;
    logic  skid_valid_reg, skid_valid_next;
    res_t  out_reg, skid_reg;
    res_t  res;

    logic  in_acc;
    logic  out_acc;

    assign in_stall = skid_valid_reg;
    assign in_acc   = in_valid && !skid_valid_reg;
    assign out_acc  = out_valid_reg && !out_stall;

    function automatic logic key_ok(input logic [3:0] k);
        return (k >= 4'd1) && (k <= KEY_LIM_V);
    endfunction

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alt_key_reg      <= ALT_KEY_RESET;
            remote_en_reg    <= 1'b0;
            first_delay_reg  <= FIRST_DELAY_RESET;
            repeat_delay_reg <= REPEAT_DELAY_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ALT_KEY:      alt_key_reg      <= cfg_data[3:0];
                CFG_REMOTE_EN:    remote_en_reg    <= cfg_data[0];
                CFG_FIRST_DELAY:  first_delay_reg  <= cfg_data;
                CFG_REPEAT_DELAY: repeat_delay_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // One pass over the accepted word: mask commands, merge, encode, autorepeat, pulse timer
    always_comb
    begin
        logic [31:0] w2;
        logic [31:0] ticks32;
        logic [31:0] dt;
        logic [31:0] lim;
        logic [3:0]  pk;
        logic [3:0]  ck;
        logic        lvl;

        scan0_next       = scan0_reg;
        scan1_next       = scan1_reg;
        vmask0_next      = vmask0_reg;
        vmask1_next      = vmask1_reg;
        rpt_key_next     = rpt_key_reg;
        rpt_time_next    = rpt_time_reg;
        rpt_started_next = rpt_started_reg;
        ticks_next       = ticks_reg;
        res              = '0;

        w2      = raw_word2;
        ticks32 = 32'(ticks_reg);
        dt      = now_ms - rpt_time_reg;
        lim     = rpt_started_reg ? 32'(repeat_delay_reg) : 32'(first_delay_reg);
        lvl     = (raw_word2 & REMOTE_BIT) != 32'h0;
        pk      = 4'd0;
        ck      = 4'd0;

        // Scan for the first held and first newly held key, last to first
        for (int k = KEY_LIM; k >= 1; k--)
        begin
            if (key_held(raw_word0, raw_word1, 4'(k)))
                pk = 4'(k);
            if (key_held(raw_word0, raw_word1, 4'(k))
                && !key_held(scan0_reg, scan1_reg, 4'(k)))
                ck = 4'(k);
        end

        if (in_acc)
        begin
            unique case (mode)
                MODE_VPRESS:
                begin
                    if (key_ok(key_index))
                    begin
                        if (key_grp(key_index))
                            vmask1_next = vmask1_reg & ~key_mask(key_index);
                        else
                            vmask0_next = vmask0_reg & ~key_mask(key_index);
                    end
                end
                MODE_VRELEASE:
                begin
                    if (key_ok(key_index))
                    begin
                        if (key_grp(key_index))
                            vmask1_next = vmask1_reg | key_mask(key_index);
                        else
                            vmask0_next = vmask0_reg | key_mask(key_index);
                    end
                end
                MODE_RELEASE_ALL:
                begin
                    vmask0_next = vmask0_reg | GRP_MASK0;
                    vmask1_next = vmask1_reg | GRP_MASK1;
                end
                MODE_CLEAR_REPEAT:
                    rpt_key_next = 4'd0;
                MODE_SCAN:
                begin
                    scan0_next = raw_word0;
                    scan1_next = raw_word1;

                    // Merge virtual presses, or force the alternate key's bits high in word one
                    if (override_on)
                    begin
                        res.word0 = (raw_word0 | GRP_MASK0) & (~GRP_MASK0 | vmask0_reg);
                        res.word1 = (raw_word1 | GRP_MASK1) & (~GRP_MASK1 | vmask1_reg);
                    end
                    else
                    begin
                        res.word0 = raw_word0;
                        res.word1 = raw_word1;
                        if (key_ok(alt_key_reg))
                            res.word1 = raw_word1 | key_mask(alt_key_reg);
                    end

                    // Remote pulse timer: count while high, report on the falling level
                    if (lvl)
                    begin
                        if (ticks_reg != TICK_SAT)
                            ticks_next = ticks_reg + 1'b1;
                    end
                    else if (ticks_reg != '0)
                    begin
                        res.pulse_len  = (ticks32 > 32'(LEN_MAX)) ? LEN_MAX : ticks32[15:0];
                        res.pulse_done = 1'b1;
                        ticks_next     = '0;
                    end
                    res.level = lvl;
                    res.word2 = w2 & ~(RO_FLAG | (remote_en_reg ? REMOTE_BIT : 32'h0));

                    res.pressed = pk;
                    res.clicked = ck;

                    // Autorepeat follows the raw scan
                    if (ck != 4'd0)
                    begin
                        rpt_key_next     = ck;
                        rpt_started_next = 1'b0;
                        rpt_time_next    = now_ms;
                        res.rpt_key      = ck;
                    end
                    else if (key_ok(rpt_key_reg)
                             && key_held(raw_word0, raw_word1, rpt_key_reg))
                    begin
                        if (!dt[31] && (dt > lim))
                        begin
                            rpt_started_next = 1'b1;
                            rpt_time_next    = now_ms;
                            res.rpt_key      = rpt_key_reg;
                        end
                    end
                    else
                        rpt_key_next = 4'd0;
                end
                default: ;
            endcase
        end
    end

    // Result buffer control: fill the output register first, spill to skid when stalled
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || out_acc)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
                out_valid_next = in_acc;
        end
        else if (in_acc)
            skid_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan0_reg       <= '0;
            scan1_reg       <= '0;
            vmask0_reg      <= GRP_MASK0;
            vmask1_reg      <= GRP_MASK1;
            rpt_key_reg     <= '0;
            rpt_time_reg    <= '0;
            rpt_started_reg <= 1'b0;
            ticks_reg       <= '0;
            out_valid_reg   <= 1'b0;
            skid_valid_reg  <= 1'b0;
        end
        else
        begin
            scan0_reg       <= scan0_next;
            scan1_reg       <= scan1_next;
            vmask0_reg      <= vmask0_next;
            vmask1_reg      <= vmask1_next;
            rpt_key_reg     <= rpt_key_next;
            rpt_time_reg    <= rpt_time_next;
            rpt_started_reg <= rpt_started_next;
            ticks_reg       <= ticks_next;
            out_valid_reg   <= out_valid_next;
            skid_valid_reg  <= skid_valid_next;
        end
    end

    // Result payload: no reset needed
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_acc)
            out_reg <= skid_valid_reg ? skid_reg : res;
        if (out_valid_reg && !out_acc && in_acc)
            skid_reg <= res;
    end

    assign out_valid         = out_valid_reg;
    assign out_word0         = out_reg.word0;
    assign out_word1         = out_reg.word1;
    assign out_word2         = out_reg.word2;
    assign pressed_key       = out_reg.pressed;
    assign clicked_key       = out_reg.clicked;
    assign repeat_key        = out_reg.rpt_key;
    assign remote_level      = out_reg.level;
    assign remote_pulse_len  = out_reg.pulse_len;
    assign remote_pulse_done = out_reg.pulse_done;

endmodule

@@ rtl/kpd_ar_checker.sv @@
// Port-level checker for keypad_override_autorepeat_core, bound to the top level.
// Depends only on the top level's ports.

module kpd_ar_port_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] out_word1,
    input logic [3:0]  pressed_key,
    input logic [3:0]  clicked_key,
    input logic [3:0]  repeat_key,
    input logic        remote_level,
    input logic [15:0] remote_pulse_len,
    input logic        remote_pulse_done
);

    // A stalled word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_word1)
                                   && $stable(repeat_key) && $stable(remote_pulse_len))
        else $error("stalled result word changed");

    // Pulse length only reported with the end of a pulse
    a_len_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !remote_pulse_done |-> remote_pulse_len == 16'd0)
        else $error("pulse length without pulse end");

    // A pulse ends on a low level and is at least one tick long
    a_pulse_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && remote_pulse_done |-> !remote_level && remote_pulse_len != 16'd0)
        else $error("bad pulse end report");

    // A click is also the repeat event, and some key at or before it is held
    a_click: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && clicked_key != 4'd0 |->
            repeat_key == clicked_key && pressed_key != 4'd0 && pressed_key <= clicked_key)
        else $error("click without matching repeat or pressed key");

endmodule

bind keypad_override_autorepeat_core kpd_ar_port_checker u_kpd_ar_checker (.*);

@@ test/kpd_ar_checker.sv @@
// Checker for the keypad override and autorepeat core: watches both channels
// and the register port, predicts each result word and compares it field by field.
// Depends on kpd_ar_pkg for the result type, mode and register codes, and masks.

module kpd_ar_checker #(
    parameter int KEY_COUNT        = 14,
    parameter int PULSE_COUNT_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [2:0]  mode,
    input  logic [3:0]  key_index,
    input  logic [31:0] raw_word0,
    input  logic [31:0] raw_word1,
    input  logic [31:0] raw_word2,
    input  logic        override_on,
    input  logic [31:0] now_ms,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [31:0] out_word0,
    input  logic [31:0] out_word1,
    input  logic [31:0] out_word2,
    input  logic [3:0]  pressed_key,
    input  logic [3:0]  clicked_key,
    input  logic [3:0]  repeat_key,
    input  logic        remote_level,
    input  logic [15:0] remote_pulse_len,
    input  logic        remote_pulse_done,
    output int          mismatches,
    output int          reports_waiting,
    output int          reports_checked,
    output int          repeats_seen,
    output int          pulses_seen
);

    import kpd_ar_pkg::*;

    localparam int KEY_LIMIT = (KEY_COUNT < TABLE_KEYS) ? KEY_COUNT : TABLE_KEYS;
    localparam longint unsigned TICK_MAX = (64'd1 << PULSE_COUNT_BITS) - 64'd1;

    // Register copies
    logic [3:0]  alt_key;
    logic        remote_en;
    logic [15:0] first_dly;
    logic [15:0] rpt_dly;

    // Scan history (only words zero and one carry keys), virtual mask, repeat state
    logic [31:0] prev_w0, prev_w1, cur_w0, cur_w1;
    logic [31:0] vmask0, vmask1;
    logic [3:0]  last_key;
    logic [31:0] last_time;
    logic        started;
    longint unsigned ticks;

    res_t pending_reports[$];

    function automatic logic [31:0] switch_bits(input logic [3:0] k);
        case (k)
            4'd1:    return 32'h1000_0000;
            4'd2:    return 32'h0000_0100;
            4'd3:    return 32'h0000_0200;
            4'd4:    return 32'h0010_0000;
            4'd5:    return 32'h0002_0000;
            4'd6:    return 32'h0008_0000;
            4'd7:    return 32'h0200_0000;
            4'd8:    return 32'h0400_0000;
            4'd9:    return 32'h0001_0000;
            4'd10:   return 32'h0100_0000;
            4'd11:   return 32'h0004_0000;
            4'd12:   return 32'h0800_0000;
            4'd13:   return 32'h0000_000C;
            4'd14:   return 32'h0000_0004;
            default: return 32'h0;
        endcase
    endfunction

    function automatic logic in_table(input logic [3:0] k);
        return (k >= 4'd1) && (int'(k) <= KEY_LIMIT);
    endfunction

    // Active low: held when all bits of the key read zero; keys 1..12 live in word one
    function automatic logic is_down(input logic [31:0] w0, input logic [31:0] w1,
                                     input logic [3:0] k);
        logic [31:0] w;
        w = (k <= 4'd12) ? w1 : w0;
        return (w & switch_bits(k)) == 32'h0;
    endfunction

    task automatic predict_report(output res_t r);
        logic [31:0] w0, w1, w2, dt, lim;
        logic [3:0]  k;
        r = '0;
        case (mode)
            MODE_VPRESS, MODE_VRELEASE:
            begin
                if (in_table(key_index))
                begin
                    if (key_index <= 4'd12)
                        vmask1 = (mode == MODE_VPRESS) ? (vmask1 & ~switch_bits(key_index))
                                                       : (vmask1 | switch_bits(key_index));
                    else
                        vmask0 = (mode == MODE_VPRESS) ? (vmask0 & ~switch_bits(key_index))
                                                       : (vmask0 | switch_bits(key_index));
                end
            end
            MODE_RELEASE_ALL:
            begin
                vmask0 = vmask0 | GRP_MASK0;
                vmask1 = vmask1 | GRP_MASK1;
            end
            MODE_CLEAR_REPEAT:
                last_key = 4'd0;
            MODE_SCAN:
            begin
                prev_w0 = cur_w0;
                prev_w1 = cur_w1;
                cur_w0  = raw_word0;
                cur_w1  = raw_word1;
                if (override_on)
                begin
                    w0 = (raw_word0 | GRP_MASK0) & (~GRP_MASK0 | vmask0);
                    w1 = (raw_word1 | GRP_MASK1) & (~GRP_MASK1 | vmask1);
                end
                else
                begin
                    w0 = raw_word0;
                    w1 = raw_word1 | (in_table(alt_key) ? switch_bits(alt_key) : 32'h0);
                end
                w2 = raw_word2;
                r.level = (w2 & REMOTE_BIT) != 32'h0;
                if (r.level)
                begin
                    if (ticks < TICK_MAX)
                        ticks++;
                end
                else if (ticks != 0)
                begin
                    r.pulse_len  = (ticks > LEN_MAX) ? LEN_MAX : ticks[15:0];
                    r.pulse_done = 1'b1;
                    ticks = 0;
                end
                r.word0 = w0;
                r.word1 = w1;
                r.word2 = w2 & ~(RO_FLAG | (remote_en ? REMOTE_BIT : 32'h0));
                for (k = 4'd1; int'(k) <= KEY_LIMIT && k != 4'd0; k++)
                begin
                    if (r.pressed == 4'd0 && is_down(cur_w0, cur_w1, k))
                        r.pressed = k;
                    if (r.clicked == 4'd0 && is_down(cur_w0, cur_w1, k)
                        && !is_down(prev_w0, prev_w1, k))
                        r.clicked = k;
                end
                // Click restarts the repeat timer; a held key repeats after the delay
                if (r.clicked != 4'd0)
                begin
                    last_key  = r.clicked;
                    started   = 1'b0;
                    last_time = now_ms;
                    r.rpt_key = r.clicked;
                end
                else if (in_table(last_key) && is_down(cur_w0, cur_w1, last_key))
                begin
                    dt  = now_ms - last_time;
                    lim = {16'h0, started ? rpt_dly : first_dly};
                    if (!dt[31] && dt > lim)
                    begin
                        started   = 1'b1;
                        last_time = now_ms;
                        r.rpt_key = last_key;
                    end
                end
                else
                    last_key = 4'd0;
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("MISMATCH word %0d field %s: expected %h, actual %h",
                         reports_checked, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        if (!rst_n)
        begin
            alt_key   = ALT_KEY_RESET;
            remote_en = 1'b0;
            first_dly = FIRST_DELAY_RESET;
            rpt_dly   = REPEAT_DELAY_RESET;
            prev_w0   = '0;
            prev_w1   = '0;
            cur_w0    = '0;
            cur_w1    = '0;
            vmask0    = GRP_MASK0;
            vmask1    = GRP_MASK1;
            last_key  = '0;
            last_time = '0;
            started   = 1'b0;
            ticks     = 0;
            pending_reports.delete();
            mismatches      = 0;
            reports_waiting = 0;
            reports_checked = 0;
            repeats_seen    = 0;
            pulses_seen     = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_reports.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("MISMATCH word %0d arrived with nothing pending",
                                 reports_checked);
                end
                else
                begin
                    want = pending_reports.pop_front();
                    check_field("out_word0", want.word0, out_word0);
                    check_field("out_word1", want.word1, out_word1);
                    check_field("out_word2", want.word2, out_word2);
                    check_field("pressed_key", 32'(want.pressed), 32'(pressed_key));
                    check_field("clicked_key", 32'(want.clicked), 32'(clicked_key));
                    check_field("repeat_key", 32'(want.rpt_key), 32'(repeat_key));
                    check_field("remote_level", 32'(want.level), 32'(remote_level));
                    check_field("remote_pulse_len", 32'(want.pulse_len),
                                32'(remote_pulse_len));
                    check_field("remote_pulse_done", 32'(want.pulse_done),
                                32'(remote_pulse_done));
                end
                reports_checked++;
                if (repeat_key != 4'd0)
                    repeats_seen++;
                if (remote_pulse_done)
                    pulses_seen++;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ALT_KEY:      alt_key   = cfg_data[3:0];
                    CFG_REMOTE_EN:    remote_en = cfg_data[0];
                    CFG_FIRST_DELAY:  first_dly = cfg_data;
                    CFG_REPEAT_DELAY: rpt_dly   = cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (in_valid && !in_stall)
            begin
                predict_report(want);
                pending_reports.push_back(want);
            end
            reports_waiting = pending_reports.size();
        end
    end

endmodule

@@ test/tb_top.sv @@
// Testbench top for keypad_override_autorepeat_core: drives stimulus, the
// register port and output backpressure, and reports the verdict.
// Depends on kpd_ar_pkg and on kpd_ar_checker for prediction and comparison.

module tb_top;
    import kpd_ar_pkg::*;

    localparam int KEY_COUNT        = 14;
    localparam int PULSE_COUNT_BITS = 16;
    // Generous ceiling: every word under the heaviest stall and the longest gaps
    localparam int RUN_LIMIT        = 100_000;
    localparam int PHASE_WORDS      = 160;
    // Scans with the remote bit pinned high for one long pulse
    localparam int LONG_PULSE_SCANS = 40;
    localparam logic [2:0]  MODE_SPARE_LO = 3'd5;
    localparam logic [2:0]  MODE_SPARE_HI = 3'd7;
    localparam logic [31:0] ALL_UP        = 32'hFFFF_FFFF;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  mode = '0;
    logic [3:0]  key_index = '0;
    logic [31:0] raw_word0 = '0;
    logic [31:0] raw_word1 = '0;
    logic [31:0] raw_word2 = '0;
    logic        override_on = 1'b0;
    logic [31:0] now_ms = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] out_word0, out_word1, out_word2;
    logic [3:0]  pressed_key, clicked_key, repeat_key;
    logic        remote_level;
    logic [15:0] remote_pulse_len;
    logic        remote_pulse_done;

    int mismatches, reports_waiting, reports_checked, repeats_seen, pulses_seen;

    // Sender burst state and the evolving key/remote/clock picture
    int          burst_left = 0;
    bit          steady = 1'b0;
    logic [14:0] held_keys = '0;
    bit          remote_on = 1'b0;
    bit          remote_pinned = 1'b0;
    logic [31:0] clock_ms = '0;
    int          settings_applied = 0;

    // Receiver stall pattern state
    int          stall_style = 0;
    int          stall_left = 0;
    int          stall_tick = 0;
    int unsigned cycle_count = 0;

    always #5 clk = ~clk;

    keypad_override_autorepeat_core #(
        .KEY_COUNT        (KEY_COUNT),
        .PULSE_COUNT_BITS (PULSE_COUNT_BITS)
    ) i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .mode              (mode),
        .key_index         (key_index),
        .raw_word0         (raw_word0),
        .raw_word1         (raw_word1),
        .raw_word2         (raw_word2),
        .override_on       (override_on),
        .now_ms            (now_ms),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .out_word0         (out_word0),
        .out_word1         (out_word1),
        .out_word2         (out_word2),
        .pressed_key       (pressed_key),
        .clicked_key       (clicked_key),
        .repeat_key        (repeat_key),
        .remote_level      (remote_level),
        .remote_pulse_len  (remote_pulse_len),
        .remote_pulse_done (remote_pulse_done)
    );

    kpd_ar_checker #(
        .KEY_COUNT        (KEY_COUNT),
        .PULSE_COUNT_BITS (PULSE_COUNT_BITS)
    ) i_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .mode              (mode),
        .key_index         (key_index),
        .raw_word0         (raw_word0),
        .raw_word1         (raw_word1),
        .raw_word2         (raw_word2),
        .override_on       (override_on),
        .now_ms            (now_ms),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .out_word0         (out_word0),
        .out_word1         (out_word1),
        .out_word2         (out_word2),
        .pressed_key       (pressed_key),
        .clicked_key       (clicked_key),
        .repeat_key        (repeat_key),
        .remote_level      (remote_level),
        .remote_pulse_len  (remote_pulse_len),
        .remote_pulse_done (remote_pulse_done),
        .mismatches        (mismatches),
        .reports_waiting   (reports_waiting),
        .reports_checked   (reports_checked),
        .repeats_seen      (repeats_seen),
        .pulses_seen       (pulses_seen)
    );

    // Abort a hung run; the count starts at time zero so reset is included
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d words still pending",
                     cycle_count, reports_waiting);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Receiver: switch at random between no stall, light stall, heavy stall and a
    // periodic pattern, so stalls land on every phase
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_style = $urandom_range(0, 3);
            stall_left  = $urandom_range(64, 512);
        end
        else
            stall_left = stall_left - 1;
        stall_tick = stall_tick + 1;
        case (stall_style)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= ((stall_tick % 5) < 2);
        endcase
    end

    // Present one word and hold it until accepted. Between bursts, drop valid
    // for a random gap first; in steady mode keep streaming.
    task automatic send_word(input logic [2:0] m, input logic [3:0] k,
                             input logic [31:0] r0, input logic [31:0] r1,
                             input logic [31:0] r2, input logic ovr,
                             input logic [31:0] t);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = (steady || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left = burst_left - 1;
        @(negedge clk);
        mode        <= m;
        key_index   <= k;
        raw_word0   <= r0;
        raw_word1   <= r1;
        raw_word2   <= r2;
        override_on <= ovr;
        now_ms      <= t;
        in_valid    <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic scan(input logic [31:0] r0, input logic [31:0] r1,
                        input logic [31:0] r2, input logic ovr, input logic [31:0] t);
        send_word(MODE_SCAN, 4'd0, r0, r1, r2, ovr, t);
    endtask

    // Commands carry random junk in the fields they ignore
    task automatic command(input logic [2:0] m, input logic [3:0] k);
        send_word(m, k, $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)), $urandom);
    endtask

    // Drain the core, then write all four registers back to back
    task automatic apply_settings(input logic [3:0] alt, input logic ren,
                                  input logic [15:0] first_dly, input logic [15:0] rpt_dly);
        logic [15:0] junk;
        @(negedge clk);
        in_valid <= 1'b0;
        burst_left = 0;
        while (reports_waiting != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
        junk = 16'($urandom);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ALT_KEY;
        cfg_data  <= {junk[15:4], alt};
        @(negedge clk);
        cfg_index <= CFG_REMOTE_EN;
        cfg_data  <= {junk[14:0], ren};
        @(negedge clk);
        cfg_index <= CFG_FIRST_DELAY;
        cfg_data  <= first_dly;
        @(negedge clk);
        cfg_index <= CFG_REPEAT_DELAY;
        cfg_data  <= rpt_dly;
        @(negedge clk);
        cfg_we <= 1'b0;
        settings_applied++;
    endtask

    // Well-formed scan: a slowly changing set of held keys over random
    // non-key bits, a remote level with runs, and a mostly 10 ms clock.
    task automatic random_scan();
        int          pick;
        int          i;
        logic [31:0] r0, r1, r2;
        i = $urandom_range(1, 14);
        if ($urandom_range(0, 5) == 0)
            held_keys[i] = !held_keys[i];
        if ($urandom_range(0, 29) == 0)
            held_keys = '0;
        if (!remote_pinned && $urandom_range(0, 7) == 0)
            remote_on = !remote_on;
        pick = $urandom_range(0, 99);
        if (pick < 75)
            clock_ms = clock_ms + 32'd10;
        else if (pick < 85)
            clock_ms = clock_ms + $urandom_range(0, 40);
        else if (pick < 90)
            clock_ms = clock_ms + $urandom_range(60000, 80000);
        else if (pick < 94)
            clock_ms = clock_ms - $urandom_range(1, 50);
        else if (pick < 97)
            clock_ms = $urandom;
        else
            clock_ms = 32'hFFFF_FFF0 + $urandom_range(0, 15);
        r0 = $urandom | GRP_MASK0;
        r1 = $urandom | GRP_MASK1;
        for (i = 1; i <= 14; i++)
        begin
            if (held_keys[i])
            begin
                if (key_grp(4'(i)))
                    r1 = r1 & ~key_mask(4'(i));
                else
                    r0 = r0 & ~key_mask(4'(i));
            end
        end
        // Now and then throw in raw noise, half-held key 13 included
        if ($urandom_range(0, 9) == 0)
        begin
            r0 = $urandom;
            r1 = $urandom;
        end
        r2 = $urandom;
        r2 = remote_on ? (r2 | REMOTE_BIT) : (r2 & ~REMOTE_BIT);
        scan(r0, r1, r2, 1'($urandom_range(0, 1)), clock_ms);
    endtask

    task automatic random_word();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            command(MODE_VPRESS, 4'($urandom_range(0, 15)));
        else if (pick < 14)
            command(MODE_VRELEASE, 4'($urandom_range(0, 15)));
        else if (pick < 16)
            command(MODE_RELEASE_ALL, 4'($urandom_range(0, 15)));
        else if (pick < 18)
            command(MODE_CLEAR_REPEAT, 4'($urandom_range(0, 15)));
        else if (pick < 19)
            command(3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI)),
                    4'($urandom_range(0, 15)));
        else
            random_scan();
    endtask

    task automatic random_phase(input int count);
        repeat (count) random_word();
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, on register reset values (alt key 1, delays 500/175).
        // All-zero scan right after reset: everything held, but no click.
        scan(32'h0, 32'h0, 32'h0, 1'b0, 32'd0);
        // All released; remote bit high, read-only flag must be cleared
        scan(ALL_UP, ALL_UP, ALL_UP, 1'b0, 32'd10);
        // All held again: click on key 1, remote pulse of one tick ends
        scan(32'h0, 32'h0, 32'h0, 1'b1, 32'd20);
        // Virtual presses: key 0 and key 15 are out of range and ignored
        command(MODE_VPRESS, 4'd0);
        command(MODE_VPRESS, 4'd15);
        command(MODE_VPRESS, 4'd1);
        command(MODE_VPRESS, 4'd13);
        command(MODE_VPRESS, 4'd14);
        command(MODE_VRELEASE, 4'd13);
        scan(ALL_UP, ALL_UP, ALL_UP, 1'b1, 32'd30);
        command(MODE_RELEASE_ALL, 4'd0);
        scan(ALL_UP, ALL_UP, ALL_UP & ~REMOTE_BIT, 1'b1, 32'd40);
        // Autorepeat on key 5: first delay is strict, then the repeat delay
        scan(ALL_UP, ALL_UP & ~key_mask(4'd5), 32'h0, 1'b0, 32'd1000);
        scan(ALL_UP, ALL_UP & ~key_mask(4'd5), 32'h0, 1'b0, 32'd1500);
        scan(ALL_UP, ALL_UP & ~key_mask(4'd5), 32'h0, 1'b0, 32'd1501);
        scan(ALL_UP, ALL_UP & ~key_mask(4'd5), 32'h0, 1'b0, 32'd1676);
        scan(ALL_UP, ALL_UP & ~key_mask(4'd5), 32'h0, 1'b0, 32'd1677);
        // Drop the repeat key: a still-held key gives no more repeats
        command(MODE_CLEAR_REPEAT, 4'd0);
        scan(ALL_UP, ALL_UP & ~key_mask(4'd5), 32'h0, 1'b0, 32'd5000);
        // Clock wrap: click key 14 just before wrap, repeat just after,
        // then a backwards step reads as negative elapsed time
        scan(ALL_UP, ALL_UP, 32'h0, 1'b0, 32'hFFFF_FFF0);
        scan(ALL_UP & ~key_mask(4'd14), ALL_UP, 32'h0, 1'b0, 32'hFFFF_FFFF);
        scan(ALL_UP & ~key_mask(4'd14), ALL_UP, 32'h0, 1'b0, 32'h0000_0200);
        scan(ALL_UP & ~key_mask(4'd14), ALL_UP, 32'h0, 1'b0, 32'h0000_0100);
        // Unused modes change nothing
        command(MODE_SPARE_LO, 4'd1);
        command(MODE_SPARE_HI, 4'd15);

        // Random phases over several settings, extremes included
        apply_settings(4'd3, 1'b1, 16'd30, 16'd10);
        random_phase(PHASE_WORDS);
        apply_settings(4'd14, 1'b0, 16'd0, 16'd0);
        random_phase(PHASE_WORDS);
        apply_settings(4'd0, 1'b1, 16'hFFFF, 16'hFFFF);
        random_phase(PHASE_WORDS);
        apply_settings(4'd15, 1'b0, FIRST_DELAY_RESET, REPEAT_DELAY_RESET);
        random_phase(PHASE_WORDS);
        apply_settings(4'($urandom_range(1, 14)), 1'($urandom_range(0, 1)),
                       16'($urandom_range(0, 100)), 16'($urandom_range(0, 60)));
        random_phase(PHASE_WORDS);

        // Hold the remote bit high over many scans for one long pulse,
        // streaming without sender gaps, then release it
        apply_settings(4'd7, 1'b1, 16'd20, 16'd20);
        steady        = 1'b1;
        remote_pinned = 1'b1;
        remote_on     = 1'b1;
        repeat (LONG_PULSE_SCANS) random_scan();
        remote_pinned = 1'b0;
        remote_on     = 1'b0;
        random_scan();
        steady = 1'b0;

        // Drain and let the output register settle
        @(negedge clk);
        in_valid <= 1'b0;
        while (reports_waiting != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);

        $display("Checked %0d result words over %0d register settings, incl. a long pulse",
                 reports_checked, settings_applied + 1);
        $display("Saw %0d click/autorepeat events and %0d finished remote pulses",
                 repeats_seen, pulses_seen);
        if (mismatches == 0 && reports_waiting == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
